>>> hdl/lbc32_pkg.sv
// ============================================================================
// lbc32_pkg
// Shared widths, register codes and round functions of the 32-bit cipher.
// ============================================================================
package lbc32_pkg;

  localparam int unsigned BLOCK_W        = 32;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned RC_W           = 5;
  localparam int unsigned PADDR_W        = 4;
  localparam int unsigned PDATA_W        = 64;
  localparam int unsigned ROUND_COUNT_DEF = 16;

  // Register index, taken from the address bits above the 8-byte offset.
  typedef enum logic {
    REG_MASTER_KEY = 1'b0
  } reg_idx_t;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [7:0]         byte_t;

  function automatic byte_t lbc32_rol1(input byte_t x);
    return {x[6:0], x[7]};
  endfunction

  function automatic byte_t lbc32_rol2(input byte_t x);
    return {x[5:0], x[7:6]};
  endfunction

  function automatic byte_t lbc32_rol7(input byte_t x);
    return {x[0], x[7:1]};
  endfunction

  function automatic byte_t lbc32_mixf(input byte_t x);
    return (lbc32_rol1(x) & lbc32_rol7(x)) ^ lbc32_rol2(x);
  endfunction

  // One step of the key schedule for round number rc.
  function automatic key_t lbc32_next_key(input key_t k, input logic [RC_W-1:0] rc);
    key_t       kx;
    key_t       kn;
    logic [7:0] b;
    logic [7:0] t;
    kx    = k ^ {{(KEY_W-RC_W-3){1'b0}}, rc, 3'b000};
    b     = kx[63:56];
    t[0]  = b[0] ^ b[6];
    t[1]  = b[1] ^ b[7];
    for (int i = 2; i < 8; i++) begin
      t[i] = b[i] ^ t[i-2];
    end
    kn = {b & t, kx[55:0]};
    return {kn[15:0], kn[55:40], kn[39:28], kn[63:60], kn[27:16], kn[59:56]};
  endfunction

  // One round of the data path under the already updated round key.
  function automatic block_t lbc32_round(input block_t v, input key_t k);
    byte_t l0;
    byte_t l1;
    byte_t r0;
    byte_t r1;
    byte_t s0;
    byte_t s1;
    byte_t b1;
    byte_t b3;
    l0 = v[7:0];
    l1 = v[15:8];
    r0 = v[23:16];
    r1 = v[31:24];
    s0 = lbc32_mixf(l0) ^ l1 ^ {k[11:8], k[3:0]};
    s1 = lbc32_mixf(r0) ^ r1 ^ {k[15:12], k[7:4]};
    b1 = lbc32_rol1(lbc32_mixf(s0) ^ l0 ^ {k[27:24], k[19:16]});
    b3 = lbc32_rol7(lbc32_mixf(s1) ^ r0 ^ {k[31:28], k[23:20]});
    return {b3, s0, b1, s1};
  endfunction

endpackage

>>> hdl/lightweight_block_cipher_32.sv
// ============================================================================
// lightweight_block_cipher_32
// Pipelined 32-bit block cipher with a 64-bit key, one round per stage.
// ============================================================================
// Usage: write the 64-bit master key through the configuration port (byte
// address 0) while no beat is in flight, then stream plaintext beats on the
// in_ channel. Each plaintext beat produces exactly one ciphertext beat on the
// out_ channel, in order. A beat is taken at a rising edge where valid is high
// and stall is low.
// A beat accepted at one edge passes through the ROUND_COUNT stage registers
// in order before it shows on out_valid. Each of the ROUND_COUNT stages holds
// one round. Throughput is one beat per cycle while out_stall does not hold
// the pipeline, set by the combinational round logic in each stage.
// The round keys come from a free-running register chain fed by the master
// key, so stage r always sees round key r. A key write reaches the first round
// key at the same edge and each later round key in the cycle after the one
// before it, so the chain stays ahead of any beat accepted after the write.
// Reset (synchronous, active low) clears the master key and every stage's
// valid bit and holds in_stall high. When the receiver stalls a valid result,
// the whole pipeline holds and in_stall is raised; nothing is dropped.
// ============================================================================
module lightweight_block_cipher_32 #(
  parameter int unsigned ROUND_COUNT = lbc32_pkg::ROUND_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // plaintext channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lbc32_pkg::BLOCK_W-1:0] in_plaintext,
  // ciphertext channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lbc32_pkg::BLOCK_W-1:0] out_ciphertext,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lbc32_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [lbc32_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [lbc32_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import lbc32_pkg::*;

  localparam int unsigned LAST = ROUND_COUNT - 1;

  key_t     master_key_r;
  key_t     master_key_nxt;
  key_t     round_key_r [ROUND_COUNT];
  logic     stage_valid [ROUND_COUNT+1];
  block_t   stage_block [ROUND_COUNT+1];
  logic     advance;
  logic     cfg_write;
  reg_idx_t cfg_idx;

  // --------------------------------------------------------------------------
  // Configuration port. The register index sits above the 8-byte offset; the
  // offset bits are ignored.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[PADDR_W-1]);

  // The next master key also feeds the first round key, so both change at the
  // same edge.
  always_comb begin
    master_key_nxt = master_key_r;
    if (!rst_n) begin
      master_key_nxt = '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_MASTER_KEY: master_key_nxt = cfg_pwdata;
        default:        master_key_nxt = master_key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_key_r <= '0;
    end else begin
      master_key_r <= master_key_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MASTER_KEY: cfg_prdata = master_key_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Key schedule. Entry r holds the key for round r+1. It does not depend on
  // the data path, so it runs freely and needs no stall control. Entry r
  // settles once the change has passed down entries 0 to r of the chain, in
  // time for a beat accepted right after the key change to reach stage r.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    round_key_r[0] <= lbc32_next_key(master_key_nxt, RC_W'(1));
  end

  for (genvar g = 1; g < ROUND_COUNT; g++) begin : g_key
    always_ff @(posedge clk) begin
      round_key_r[g] <= lbc32_next_key(round_key_r[g-1], RC_W'(g + 1));
    end
  end

  // --------------------------------------------------------------------------
  // Data pipeline. All stages move together; they hold only while the last
  // stage carries a result that the receiver stalls. No beat is taken during
  // reset.
  // --------------------------------------------------------------------------
  assign advance  = !(stage_valid[ROUND_COUNT] && out_stall);
  assign in_stall = !advance || !rst_n;

  assign stage_valid[0] = in_valid;
  assign stage_block[0] = in_plaintext;

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    lbc32_round_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .in_valid  (stage_valid[g]),
      .in_block  (stage_block[g]),
      .round_key (round_key_r[g]),
      .out_valid (stage_valid[g+1]),
      .out_block (stage_block[g+1])
    );
  end

  assign out_valid      = stage_valid[ROUND_COUNT];
  assign out_ciphertext = stage_block[ROUND_COUNT];

`ifndef NO_ASSERTIONS
  // The first round key always follows the current master key.
  a_key_first: assert property (@(posedge clk) disable iff (!rst_n)
    round_key_r[0] == lbc32_next_key(master_key_r, RC_W'(1)))
    else $error("first round key does not follow the master key");

  // While a beat waits for the last round, its key follows its predecessor.
  a_key_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((ROUND_COUNT > 1) && stage_valid[LAST]) |-> round_key_r[LAST] ==
      lbc32_next_key($past(round_key_r[(LAST > 0) ? LAST - 1 : 0]), RC_W'(ROUND_COUNT)))
    else $error("last round key breaks the schedule chain");

  // An accepted plaintext beat occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> stage_valid[1])
    else $error("accepted beat missing from the first stage");

  // A stalled result freezes the first stage as well.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(stage_valid[1]) && $stable(stage_block[1]))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

>>> hdl/lbc32_round_stage.sv
// ============================================================================
// lbc32_round_stage
// One pipeline stage: applies a single cipher round and registers the beat.
// ============================================================================
module lbc32_round_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  logic                   in_valid,
  input  lbc32_pkg::block_t      in_block,
  input  lbc32_pkg::key_t        round_key,
  output logic                   out_valid,
  output lbc32_pkg::block_t      out_block
);
  import lbc32_pkg::*;

  logic   valid_r;
  block_t block_r;
  block_t block_nxt;

  assign block_nxt = lbc32_round(in_block, round_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      block_r <= block_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_block = block_r;

endmodule
